[sv/dsc_pkg.sv]
// Shared types, constants and grammar functions of the declaration syntax checker.
package dsc_pkg;

  localparam int COUNT_MAX   = 255;
  localparam int COUNT_W     = $clog2(COUNT_MAX + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_EQUAL  = 8'h3d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [2:0] KW_INT_LEN  = 3'd7;
  localparam logic [2:0] KW_REAL_LEN = 3'd4;

  typedef enum logic [4:0] {
    G_LEAD, G_ID, G_AFTER_ID, G_TYPE_LEAD, G_KW_INT, G_KW_REAL, G_AFTER_TYPE,
    G_DOM_LEAD, G_SET_OPEN, G_SC_INT, G_SC_DOT, G_SC_FRAC, G_SET_NEXT,
    G_SET_VALUE, G_IV_LEAD1, G_IV1_INT, G_IV1_DOT, G_IV1_FRAC, G_IV1_WS,
    G_IV_DOT2, G_IV_LEAD2, G_IV2_INT, G_IV2_DOT, G_IV2_FRAC, G_IV2_WS,
    G_DONE, G_FAIL
  } gstate_t;

  typedef struct packed {
    gstate_t              gstate;
    logic [2:0]           kidx;
    logic                 iflag;
    logic [COUNT_W-1:0]   scnt;
    logic [COUNT_W-1:0]   icnt;
  } gram_t;

  // One queue entry: the grammar work that one input word causes.
  typedef struct packed {
    logic       begin_stmt;
    logic       feed_paren;
    logic       feed_char;
    logic       emit;
    logic       closed;
    logic [7:0] char_byte;
  } qitem_t;

  localparam gram_t GRAM_RESET = '{gstate: G_LEAD, kidx: 3'd0, iflag: 1'b0,
                                   scnt: '0, icnt: '0};

  function automatic logic [7:0] kw_int_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = 8'h69;
      3'd1: ch = 8'h6e;
      3'd2: ch = 8'h74;
      3'd3: ch = 8'h65;
      3'd4: ch = 8'h67;
      3'd5: ch = 8'h65;
      3'd6: ch = 8'h72;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_real_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = 8'h72;
      3'd1: ch = 8'h65;
      3'd2: ch = 8'h61;
      3'd3: ch = 8'h6c;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] cnt);
    logic [COUNT_W-1:0] r;
    if (cnt < COUNT_W'(COUNT_MAX)) r = COUNT_W'(cnt + 1'b1);
    else r = cnt;
    return r;
  endfunction

  function automatic gram_t start_value(input gram_t s, input logic [7:0] c);
    gram_t r;
    r = s;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.scnt = bump(s.scnt);
      r.gstate = G_SC_INT;
    end else if (c == CH_LBRACK) begin
      r.gstate = G_IV_LEAD1;
    end else begin
      r.gstate = G_FAIL;
    end
    return r;
  endfunction

  // One transition of the declaration grammar.
  function automatic gram_t gram_step(input gram_t s, input logic [7:0] c);
    gram_t r;
    logic  ws;
    logic  dg;
    logic  an;
    logic  tail;
    r    = s;
    tail = 1'b0;
    ws   = (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB);
    dg   = (c >= 8'h30) && (c <= 8'h39);
    an   = dg || ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    case (s.gstate)
      G_LEAD: r.gstate = ws ? G_LEAD : ((c == CH_DOLLAR) ? G_ID : G_FAIL);
      G_ID, G_AFTER_ID: begin
        if (an && s.gstate == G_ID) r.gstate = G_ID;
        else if (ws) r.gstate = G_AFTER_ID;
        else if (c == CH_COLON) r.gstate = G_TYPE_LEAD;
        else if (c == CH_EQUAL) r.gstate = G_DOM_LEAD;
        else r.gstate = G_FAIL;
      end
      G_TYPE_LEAD: begin
        if (ws) begin
          r.gstate = G_TYPE_LEAD;
        end else begin
          r.kidx = 3'd1;
          if (c == kw_int_char(3'd0)) r.gstate = G_KW_INT;
          else if (c == kw_real_char(3'd0)) r.gstate = G_KW_REAL;
          else r.gstate = G_FAIL;
        end
      end
      G_KW_INT: begin
        if (s.kidx >= KW_INT_LEN || c != kw_int_char(s.kidx)) begin
          r.gstate = G_FAIL;
        end else begin
          r.kidx = s.kidx + 3'd1;
          if (r.kidx == KW_INT_LEN) begin
            r.iflag  = 1'b1;
            r.gstate = G_AFTER_TYPE;
          end else begin
            r.gstate = G_KW_INT;
          end
        end
      end
      G_KW_REAL: begin
        if (s.kidx >= KW_REAL_LEN || c != kw_real_char(s.kidx)) begin
          r.gstate = G_FAIL;
        end else begin
          r.kidx = s.kidx + 3'd1;
          if (r.kidx == KW_REAL_LEN) begin
            r.iflag  = 1'b0;
            r.gstate = G_AFTER_TYPE;
          end else begin
            r.gstate = G_KW_REAL;
          end
        end
      end
      G_AFTER_TYPE: r.gstate = ws ? G_AFTER_TYPE : ((c == CH_EQUAL) ? G_DOM_LEAD : G_FAIL);
      G_DOM_LEAD:   r.gstate = ws ? G_DOM_LEAD : ((c == CH_LBRACE) ? G_SET_OPEN : G_FAIL);
      G_SET_OPEN: begin
        if (ws) r.gstate = G_SET_OPEN;
        else if (c == CH_RBRACE) r.gstate = G_DONE;
        else r = start_value(s, c);
      end
      G_SC_INT, G_SET_NEXT: begin
        if (s.gstate == G_SC_INT && dg) r.gstate = G_SC_INT;
        else if (s.gstate == G_SC_INT && c == CH_DOT) r.gstate = G_SC_DOT;
        else if (ws) r.gstate = G_SET_NEXT;
        else if (c == CH_COMMA) r.gstate = G_SET_VALUE;
        else if (c == CH_RBRACE) r.gstate = G_DONE;
        else r.gstate = G_FAIL;
      end
      G_SC_DOT: r.gstate = dg ? G_SC_FRAC : G_FAIL;
      G_SC_FRAC: begin
        if (dg) r.gstate = G_SC_FRAC;
        else if (ws) r.gstate = G_SET_NEXT;
        else if (c == CH_COMMA) r.gstate = G_SET_VALUE;
        else if (c == CH_RBRACE) r.gstate = G_DONE;
        else r.gstate = G_FAIL;
      end
      G_SET_VALUE: begin
        if (ws) r.gstate = G_SET_VALUE;
        else r = start_value(s, c);
      end
      G_IV_LEAD1: r.gstate = ws ? G_IV_LEAD1 : (dg ? G_IV1_INT : G_FAIL);
      G_IV1_INT: begin
        if (dg) r.gstate = G_IV1_INT;
        else if (c == CH_DOT) r.gstate = G_IV1_DOT;
        else r.gstate = ws ? G_IV1_WS : G_FAIL;
      end
      G_IV1_DOT: begin
        if (dg) r.gstate = G_IV1_FRAC;
        else r.gstate = (c == CH_DOT) ? G_IV_LEAD2 : G_FAIL;
      end
      G_IV1_FRAC: begin
        if (dg) r.gstate = G_IV1_FRAC;
        else if (c == CH_DOT) r.gstate = G_IV_DOT2;
        else r.gstate = ws ? G_IV1_WS : G_FAIL;
      end
      G_IV1_WS:   r.gstate = ws ? G_IV1_WS : ((c == CH_DOT) ? G_IV_DOT2 : G_FAIL);
      G_IV_DOT2:  r.gstate = (c == CH_DOT) ? G_IV_LEAD2 : G_FAIL;
      G_IV_LEAD2: r.gstate = ws ? G_IV_LEAD2 : (dg ? G_IV2_INT : G_FAIL);
      G_IV2_INT: begin
        if (dg) r.gstate = G_IV2_INT;
        else if (c == CH_DOT) r.gstate = G_IV2_DOT;
        else tail = 1'b1;
      end
      G_IV2_DOT: r.gstate = dg ? G_IV2_FRAC : G_FAIL;
      G_IV2_FRAC: begin
        if (dg) r.gstate = G_IV2_FRAC;
        else tail = 1'b1;
      end
      G_IV2_WS: tail = 1'b1;
      G_DONE:   r.gstate = G_DONE;
      default:  r.gstate = G_FAIL;
    endcase
    // The second bound of an interval ends in whitespace or the closing bracket.
    if (tail) begin
      if (ws) begin
        r.gstate = G_IV2_WS;
      end else if (c == CH_RBRACK) begin
        r.icnt   = bump(s.icnt);
        r.gstate = G_SET_NEXT;
      end else begin
        r.gstate = G_FAIL;
      end
    end
    return r;
  endfunction

endpackage

[sv/dsc_in_if.sv]
// Input channel: one text character per word.
interface dsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_text;

  modport source (output valid, output char_byte, output end_of_text, input ready);
  modport sink (input valid, input char_byte, input end_of_text, output ready);
endinterface

[sv/dsc_out_if.sv]
// Output channel: one statement verdict per word.
interface dsc_out_if;
  logic       valid;
  logic       ready;
  logic       decl_valid;
  logic       type_integer;
  logic [7:0] scalar_total;
  logic [7:0] interval_total;
  logic       was_closed;

  modport source (output valid, output decl_valid, output type_integer,
                  output scalar_total, output interval_total, output was_closed,
                  input ready);
  modport sink (input valid, input decl_valid, input type_integer,
                input scalar_total, input interval_total, input was_closed,
                output ready);
endinterface

[sv/dsc_front.sv]
// Front end: tracks the double-parenthesis framing and turns characters into grammar work.
module dsc_front (
  input  logic              clk,
  input  logic              rst,
  dsc_in_if.sink            in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output dsc_pkg::qitem_t   push_item
);

  typedef enum logic [1:0] {PH_OUTSIDE, PH_OPEN1, PH_INSIDE, PH_CLOSE1} phase_t;

  phase_t          phase;
  phase_t          phase_next;
  dsc_pkg::qitem_t item;
  logic            needs_push;

  always_comb begin
    item            = '0;
    item.char_byte  = in_ch.char_byte;
    phase_next      = phase;
    case (phase)
      PH_OUTSIDE: begin
        if (in_ch.char_byte == dsc_pkg::CH_LPAREN) phase_next = PH_OPEN1;
      end
      PH_OPEN1: begin
        if (in_ch.char_byte == dsc_pkg::CH_LPAREN) begin
          phase_next      = PH_INSIDE;
          item.begin_stmt = 1'b1;
        end else begin
          phase_next = PH_OUTSIDE;
        end
      end
      PH_INSIDE: begin
        if (in_ch.char_byte == dsc_pkg::CH_RPAREN) phase_next = PH_CLOSE1;
        else item.feed_char = 1'b1;
      end
      PH_CLOSE1: begin
        if (in_ch.char_byte == dsc_pkg::CH_RPAREN) begin
          item.emit   = 1'b1;
          item.closed = 1'b1;
          phase_next  = PH_OUTSIDE;
        end else begin
          // A lone ')' belongs to the statement and goes in ahead of this character.
          item.feed_paren = 1'b1;
          item.feed_char  = 1'b1;
          phase_next      = PH_INSIDE;
        end
      end
      default: phase_next = PH_OUTSIDE;
    endcase
    if (in_ch.end_of_text) begin
      if (phase_next == PH_CLOSE1) begin
        item.feed_paren = 1'b1;
        item.emit       = 1'b1;
        item.closed     = 1'b0;
      end else if (phase_next == PH_INSIDE) begin
        item.emit   = 1'b1;
        item.closed = 1'b0;
      end
      phase_next = PH_OUTSIDE;
    end
  end

  assign needs_push  = item.begin_stmt | item.feed_paren | item.feed_char | item.emit;
  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid & needs_push;
  assign push_item   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_OUTSIDE;
    end else if (in_ch.valid && in_ch.ready) begin
      phase <= phase_next;
    end
  end

endmodule

[sv/dsc_queue.sv]
// Short FIFO of grammar work between the front and back ends.
module dsc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  dsc_pkg::qitem_t   push_item,
  output logic              pop_valid,
  input  logic              pop_ready,
  output dsc_pkg::qitem_t   pop_item
);

  dsc_pkg::qitem_t               slots [dsc_pkg::QUEUE_DEPTH];
  logic [dsc_pkg::QPTR_W-1:0]    wr_ptr;
  logic [dsc_pkg::QPTR_W-1:0]    rd_ptr;
  logic [dsc_pkg::QPTR_W:0]      fill;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = fill != (dsc_pkg::QPTR_W + 1)'(dsc_pkg::QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= dsc_pkg::QPTR_W'((wr_ptr + 1'b1) % dsc_pkg::QUEUE_DEPTH);
      if (do_pop)  rd_ptr <= dsc_pkg::QPTR_W'((rd_ptr + 1'b1) % dsc_pkg::QUEUE_DEPTH);
      if (do_push && !do_pop) fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (dsc_pkg::QPTR_W + 1)'(dsc_pkg::QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (fill != '0 && fill != (dsc_pkg::QPTR_W + 1)'(dsc_pkg::QUEUE_DEPTH))
      |-> (dsc_pkg::QPTR_W'(wr_ptr - rd_ptr) == dsc_pkg::QPTR_W'(fill)))
    else $error("queue pointers disagree with fill");

endmodule

[sv/dsc_back.sv]
// Back end: runs the declaration grammar and registers one verdict per statement.
module dsc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  dsc_pkg::qitem_t   pop_item,
  dsc_out_if.source         out_ch
);

  dsc_pkg::gram_t gram;
  dsc_pkg::gram_t g_base;
  dsc_pkg::gram_t g_paren;
  dsc_pkg::gram_t gram_next;
  logic           out_valid;
  logic           do_pop;
  logic           ok;

  // Up to two grammar steps per word: a deferred ')' and then the character.
  always_comb begin
    g_base    = pop_item.begin_stmt ? dsc_pkg::GRAM_RESET : gram;
    g_paren   = pop_item.feed_paren ? dsc_pkg::gram_step(g_base, dsc_pkg::CH_RPAREN) : g_base;
    gram_next = pop_item.feed_char ? dsc_pkg::gram_step(g_paren, pop_item.char_byte) : g_paren;
  end

  assign ok        = gram_next.gstate == dsc_pkg::G_DONE;
  assign pop_ready = !pop_item.emit || !out_valid || out_ch.ready;
  assign do_pop    = pop_valid & pop_ready;
  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      gram      <= dsc_pkg::GRAM_RESET;
      out_valid <= 1'b0;
    end else begin
      if (do_pop) gram <= gram_next;
      if (do_pop && pop_item.emit) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && pop_item.emit) begin
      out_ch.decl_valid     <= ok;
      out_ch.type_integer   <= ok & gram_next.iflag;
      out_ch.scalar_total   <= ok ? 8'(gram_next.scnt) : 8'd0;
      out_ch.interval_total <= ok ? 8'(gram_next.icnt) : 8'd0;
      out_ch.was_closed     <= pop_item.closed;
    end
  end

  a_invalid_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.decl_valid)
      |-> (!out_ch.type_integer && out_ch.scalar_total == 8'd0
           && out_ch.interval_total == 8'd0))
    else $error("invalid verdict carries type or counts");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    gram.scnt <= dsc_pkg::COUNT_W'(dsc_pkg::COUNT_MAX)
      && gram.icnt <= dsc_pkg::COUNT_W'(dsc_pkg::COUNT_MAX))
    else $error("value count beyond saturation limit");

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !pop_item.begin_stmt && gram.gstate == dsc_pkg::G_DONE)
      |=> gram.gstate == dsc_pkg::G_DONE)
    else $error("accepted declaration left the done state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |-> !(do_pop && pop_item.emit))
    else $error("verdict overwritten while stalled");

endmodule

[sv/declaration_syntax_checker.sv]
// Takes one character per cycle and returns one verdict word per "(( ... ))" statement.
// A word that closes a statement or ends the text yields its verdict once it has passed
// through the framing front end into a four-entry work queue, and then through the
// grammar back end into the output register. The input keeps taking a
// character every cycle while the queue has room; the back end retires one queue entry
// per cycle, each entry applying at most two grammar transitions, and stalls only when a
// verdict is due and the previous one has not yet been taken. There is no clearing pass
// after reset.
module declaration_syntax_checker (
  input  logic        clk,
  input  logic        rst,
  dsc_in_if.sink      in_ch,
  dsc_out_if.source   out_ch
);

  logic            push_valid;
  logic            push_ready;
  dsc_pkg::qitem_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  dsc_pkg::qitem_t pop_item;

  dsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  dsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  dsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_ch    (out_ch)
  );

endmodule

[tb/sv/declaration_syntax_checker_test.sv]
// Self-checking testbench for the declaration syntax checker: statement texts in, verdicts checked.
module declaration_syntax_checker_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 700;
  localparam int STALL_LIMIT  = 500;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [7:0] DIGIT_0 = 8'h30;
  localparam logic [7:0] LOWER_A = 8'h61;
  localparam logic [7:0] UPPER_A = 8'h41;

  typedef struct packed {
    logic       ok;
    logic       is_int;
    logic [7:0] n_scalar;
    logic [7:0] n_interval;
    logic       closed;
  } verdict_t;

  // Tracks statement framing and grammar, and holds the verdicts still owed by the block.
  class verdict_scoreboard;
    typedef enum logic [1:0] {SCAN_OUTSIDE, SCAN_OPEN1, SCAN_INSIDE, SCAN_CLOSE1} scan_t;

    scan_t            scan;
    dsc_pkg::gstate_t gs;
    logic [2:0]       kw_pos;
    logic             int_flag;
    logic [7:0]       n_sc;
    logic [7:0]       n_iv;
    string            kw_integer;
    string            kw_real;
    verdict_t         owed_verdicts[$];
    int               errors;

    function new();
      kw_integer = "integer";
      kw_real    = "real";
      scan       = SCAN_OUTSIDE;
      errors     = 0;
      open_statement();
    endfunction

    function void open_statement();
      gs       = dsc_pkg::G_LEAD;
      kw_pos   = 3'd0;
      int_flag = 1'b0;
      n_sc     = 8'd0;
      n_iv     = 8'd0;
    endfunction

    function bit is_ws(logic [7:0] c);
      return c == dsc_pkg::CH_SPACE || c == dsc_pkg::CH_NL || c == dsc_pkg::CH_TAB;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= DIGIT_0 && c <= DIGIT_0 + 8'd9;
    endfunction

    function bit is_alnum(logic [7:0] c);
      return is_digit(c) || (c >= LOWER_A && c <= LOWER_A + 8'd25) ||
             (c >= UPPER_A && c <= UPPER_A + 8'd25);
    endfunction

    function logic [7:0] bump_count(logic [7:0] n);
      return (n < dsc_pkg::COUNT_MAX) ? n + 8'd1 : n;
    endfunction

    function dsc_pkg::gstate_t first_of_value(logic [7:0] c);
      if (is_digit(c)) begin
        n_sc = bump_count(n_sc);
        return dsc_pkg::G_SC_INT;
      end
      return (c == dsc_pkg::CH_LBRACK) ? dsc_pkg::G_IV_LEAD1 : dsc_pkg::G_FAIL;
    endfunction

    function void step_grammar(logic [7:0] c);
      bit               ws;
      bit               dg;
      bit               bound_end;
      dsc_pkg::gstate_t nx;
      ws        = is_ws(c);
      dg        = is_digit(c);
      bound_end = 1'b0;
      nx        = dsc_pkg::G_FAIL;
      case (gs)
        dsc_pkg::G_LEAD: begin
          if (ws) nx = dsc_pkg::G_LEAD;
          else if (c == dsc_pkg::CH_DOLLAR) nx = dsc_pkg::G_ID;
        end
        dsc_pkg::G_ID, dsc_pkg::G_AFTER_ID: begin
          if (gs == dsc_pkg::G_ID && is_alnum(c)) nx = dsc_pkg::G_ID;
          else if (ws) nx = dsc_pkg::G_AFTER_ID;
          else if (c == dsc_pkg::CH_COLON) nx = dsc_pkg::G_TYPE_LEAD;
          else if (c == dsc_pkg::CH_EQUAL) nx = dsc_pkg::G_DOM_LEAD;
        end
        dsc_pkg::G_TYPE_LEAD: begin
          if (ws) begin
            nx = dsc_pkg::G_TYPE_LEAD;
          end else begin
            kw_pos = 3'd1;
            if (c == kw_integer[0]) nx = dsc_pkg::G_KW_INT;
            else if (c == kw_real[0]) nx = dsc_pkg::G_KW_REAL;
          end
        end
        dsc_pkg::G_KW_INT: begin
          if (kw_pos < 3'd7 && c == kw_integer[kw_pos]) begin
            kw_pos = kw_pos + 3'd1;
            if (kw_pos == 3'd7) begin
              int_flag = 1'b1;
              nx = dsc_pkg::G_AFTER_TYPE;
            end else begin
              nx = dsc_pkg::G_KW_INT;
            end
          end
        end
        dsc_pkg::G_KW_REAL: begin
          if (kw_pos < 3'd4 && c == kw_real[kw_pos]) begin
            kw_pos = kw_pos + 3'd1;
            if (kw_pos == 3'd4) begin
              int_flag = 1'b0;
              nx = dsc_pkg::G_AFTER_TYPE;
            end else begin
              nx = dsc_pkg::G_KW_REAL;
            end
          end
        end
        dsc_pkg::G_AFTER_TYPE: begin
          if (ws) nx = dsc_pkg::G_AFTER_TYPE;
          else if (c == dsc_pkg::CH_EQUAL) nx = dsc_pkg::G_DOM_LEAD;
        end
        dsc_pkg::G_DOM_LEAD: begin
          if (ws) nx = dsc_pkg::G_DOM_LEAD;
          else if (c == dsc_pkg::CH_LBRACE) nx = dsc_pkg::G_SET_OPEN;
        end
        dsc_pkg::G_SET_OPEN: begin
          if (ws) nx = dsc_pkg::G_SET_OPEN;
          else if (c == dsc_pkg::CH_RBRACE) nx = dsc_pkg::G_DONE;
          else nx = first_of_value(c);
        end
        dsc_pkg::G_SC_INT, dsc_pkg::G_SC_FRAC, dsc_pkg::G_SET_NEXT: begin
          if (gs == dsc_pkg::G_SC_INT && dg) nx = dsc_pkg::G_SC_INT;
          else if (gs == dsc_pkg::G_SC_INT && c == dsc_pkg::CH_DOT) nx = dsc_pkg::G_SC_DOT;
          else if (gs == dsc_pkg::G_SC_FRAC && dg) nx = dsc_pkg::G_SC_FRAC;
          else if (ws) nx = dsc_pkg::G_SET_NEXT;
          else if (c == dsc_pkg::CH_COMMA) nx = dsc_pkg::G_SET_VALUE;
          else if (c == dsc_pkg::CH_RBRACE) nx = dsc_pkg::G_DONE;
        end
        dsc_pkg::G_SC_DOT: begin
          if (dg) nx = dsc_pkg::G_SC_FRAC;
        end
        dsc_pkg::G_SET_VALUE: begin
          if (ws) nx = dsc_pkg::G_SET_VALUE;
          else nx = first_of_value(c);
        end
        dsc_pkg::G_IV_LEAD1: begin
          if (ws) nx = dsc_pkg::G_IV_LEAD1;
          else if (dg) nx = dsc_pkg::G_IV1_INT;
        end
        dsc_pkg::G_IV1_INT: begin
          if (dg) nx = dsc_pkg::G_IV1_INT;
          else if (c == dsc_pkg::CH_DOT) nx = dsc_pkg::G_IV1_DOT;
          else if (ws) nx = dsc_pkg::G_IV1_WS;
        end
        dsc_pkg::G_IV1_DOT: begin
          if (dg) nx = dsc_pkg::G_IV1_FRAC;
          else if (c == dsc_pkg::CH_DOT) nx = dsc_pkg::G_IV_LEAD2;
        end
        dsc_pkg::G_IV1_FRAC: begin
          if (dg) nx = dsc_pkg::G_IV1_FRAC;
          else if (c == dsc_pkg::CH_DOT) nx = dsc_pkg::G_IV_DOT2;
          else if (ws) nx = dsc_pkg::G_IV1_WS;
        end
        dsc_pkg::G_IV1_WS: begin
          if (ws) nx = dsc_pkg::G_IV1_WS;
          else if (c == dsc_pkg::CH_DOT) nx = dsc_pkg::G_IV_DOT2;
        end
        dsc_pkg::G_IV_DOT2: begin
          if (c == dsc_pkg::CH_DOT) nx = dsc_pkg::G_IV_LEAD2;
        end
        dsc_pkg::G_IV_LEAD2: begin
          if (ws) nx = dsc_pkg::G_IV_LEAD2;
          else if (dg) nx = dsc_pkg::G_IV2_INT;
        end
        dsc_pkg::G_IV2_INT: begin
          if (dg) nx = dsc_pkg::G_IV2_INT;
          else if (c == dsc_pkg::CH_DOT) nx = dsc_pkg::G_IV2_DOT;
          else bound_end = 1'b1;
        end
        dsc_pkg::G_IV2_DOT: begin
          if (dg) nx = dsc_pkg::G_IV2_FRAC;
        end
        dsc_pkg::G_IV2_FRAC: begin
          if (dg) nx = dsc_pkg::G_IV2_FRAC;
          else bound_end = 1'b1;
        end
        dsc_pkg::G_IV2_WS: bound_end = 1'b1;
        dsc_pkg::G_DONE:   nx = dsc_pkg::G_DONE;
        default:           nx = dsc_pkg::G_FAIL;
      endcase
      // The upper bound of an interval may be followed by whitespace before the bracket.
      if (bound_end) begin
        if (ws) begin
          nx = dsc_pkg::G_IV2_WS;
        end else if (c == dsc_pkg::CH_RBRACK) begin
          n_iv = bump_count(n_iv);
          nx = dsc_pkg::G_SET_NEXT;
        end
      end
      gs = nx;
    endfunction

    function void owe_verdict(logic closed);
      verdict_t v;
      v.ok         = (gs == dsc_pkg::G_DONE);
      v.is_int     = v.ok ? int_flag : 1'b0;
      v.n_scalar   = v.ok ? n_sc : 8'd0;
      v.n_interval = v.ok ? n_iv : 8'd0;
      v.closed     = closed;
      owed_verdicts.insert(owed_verdicts.size(), v);
    endfunction

    function void note_char(logic [7:0] c, logic eot);
      case (scan)
        SCAN_OUTSIDE: begin
          if (c == dsc_pkg::CH_LPAREN) scan = SCAN_OPEN1;
        end
        SCAN_OPEN1: begin
          if (c == dsc_pkg::CH_LPAREN) begin
            scan = SCAN_INSIDE;
            open_statement();
          end else begin
            scan = SCAN_OUTSIDE;
          end
        end
        SCAN_INSIDE: begin
          if (c == dsc_pkg::CH_RPAREN) scan = SCAN_CLOSE1;
          else step_grammar(c);
        end
        default: begin
          if (c == dsc_pkg::CH_RPAREN) begin
            owe_verdict(1'b1);
            scan = SCAN_OUTSIDE;
          end else begin
            // A lone closing parenthesis belongs to the statement.
            step_grammar(dsc_pkg::CH_RPAREN);
            step_grammar(c);
            scan = SCAN_INSIDE;
          end
        end
      endcase
      if (eot) begin
        if (scan == SCAN_CLOSE1) begin
          step_grammar(dsc_pkg::CH_RPAREN);
          owe_verdict(1'b0);
        end else if (scan == SCAN_INSIDE) begin
          owe_verdict(1'b0);
        end
        scan = SCAN_OUTSIDE;
      end
    endfunction

    function int pending();
      return owed_verdicts.size();
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task compare_field(string name, int got, int want);
      if (got != want) report($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task check_verdict(verdict_t got);
      verdict_t want;
      if (owed_verdicts.size() == 0) begin
        report("verdict word arrived with none outstanding");
        return;
      end
      want = owed_verdicts.pop_front();
      compare_field("decl_valid", got.ok, want.ok);
      compare_field("type_integer", got.is_int, want.is_int);
      compare_field("scalar_total", got.n_scalar, want.n_scalar);
      compare_field("interval_total", got.n_interval, want.n_interval);
      compare_field("was_closed", got.closed, want.closed);
    endtask
  endclass

  logic clk;
  logic rst;
  dsc_in_if  in_ch();
  dsc_out_if out_ch();

  declaration_syntax_checker dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  verdict_scoreboard sb = new();
  logic [7:0] text_q[$];
  int  items_sent = 0;
  int  idle_cycles = 0;
  bit  in_idle = 1'b1;
  bit  out_idle = 1'b1;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Ends the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function void add_byte(logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  function void put(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function void put_ws(int max_n);
    int n;
    n = $urandom_range(0, max_n);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0:       add_byte(dsc_pkg::CH_SPACE);
        1:       add_byte(dsc_pkg::CH_NL);
        default: add_byte(dsc_pkg::CH_TAB);
      endcase
    end
  endfunction

  function void put_number();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) add_byte(DIGIT_0 + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 2) == 0) begin
      add_byte(dsc_pkg::CH_DOT);
      n = $urandom_range(1, 2);
      repeat (n) add_byte(DIGIT_0 + 8'($urandom_range(0, 9)));
    end
  endfunction

  function void put_value();
    if ($urandom_range(0, 1) == 0) begin
      put_number();
    end else begin
      put("[");
      put_ws(1);
      put_number();
      put_ws(1);
      put("..");
      put_ws(1);
      put_number();
      put_ws(1);
      put("]");
    end
  endfunction

  // A well-formed statement with random spacing, name, type and value list.
  function void put_statement();
    int n;
    put("((");
    put_ws(2);
    put("$");
    n = $urandom_range(0, 4);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0:       add_byte(LOWER_A + 8'($urandom_range(0, 25)));
        1:       add_byte(UPPER_A + 8'($urandom_range(0, 25)));
        default: add_byte(DIGIT_0 + 8'($urandom_range(0, 9)));
      endcase
    end
    put_ws(1);
    case ($urandom_range(0, 2))
      0: ;
      1: begin put(":"); put_ws(1); put("integer"); put_ws(1); end
      default: begin put(":"); put_ws(1); put("real"); put_ws(1); end
    endcase
    put("=");
    put_ws(1);
    put("{");
    put_ws(1);
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        put(",");
        put_ws(1);
      end
      put_value();
      put_ws(1);
    end
    put("}");
    if ($urandom_range(0, 3) == 0) put("x= 1;");
    put("))");
  endfunction

  function void put_noise();
    string pool;
    int    n;
    pool = "(()){}[]$:=.,ir9 ";
    n = $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) add_byte(8'($urandom_range(0, 255)));
      else add_byte(pool[$urandom_range(0, pool.len() - 1)]);
    end
  endfunction

  task automatic send_word(input logic [7:0] c, input logic eot);
    int gap;
    gap = in_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.char_byte   <= c;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_char(c, eot);
    items_sent++;
  endtask

  // Sends the assembled text, marking its last byte as the end of text.
  task automatic send_text();
    in_idle = ($urandom_range(0, 3) != 0);
    foreach (text_q[i]) send_word(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic send_random_text();
    int    segs;
    int    start;
    string marks;
    marks = "}:=,.[]$";
    segs = $urandom_range(1, 4);
    repeat (segs) begin
      if ($urandom_range(0, 9) < 7) begin
        start = text_q.size();
        put_statement();
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            text_q[$urandom_range(start + 2, text_q.size() - 3)] = 8'($urandom_range(0, 255));
          end else begin
            text_q[$urandom_range(start + 2, text_q.size() - 3)] = marks[$urandom_range(0, 7)];
          end
        end
      end else begin
        put_noise();
      end
    end
    // Sometimes the text stops in the middle of a statement.
    if ($urandom_range(0, 5) == 0) begin
      start = text_q.size();
      put_statement();
      repeat ($urandom_range(1, text_q.size() - start - 1)) void'(text_q.pop_back());
    end
    send_text();
  endtask

  initial begin
    out_ch.ready = 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      int gap;
      verdict_t got;
      if ($urandom_range(0, 15) == 0) out_idle = !out_idle;
      gap = out_idle ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.ok         = out_ch.decl_valid;
      got.is_int     = out_ch.type_integer;
      got.n_scalar   = out_ch.scalar_total;
      got.n_interval = out_ch.interval_total;
      got.closed     = out_ch.was_closed;
      sb.check_verdict(got);
    end
  end

  initial begin
    int base;
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.char_byte   = 8'h00;
    in_ch.end_of_text = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    put("(($a:integer={0,9.25,[1..2]}))");
    send_text();
    put("(( \t$Zz9\n: real =\n{ 12 ,[ 3.5 .. 40 ] , 7 }tail))");
    send_text();
    put("(($v=x))");
    send_text();
    // A lone ')' inside the statement, then three closing parentheses.
    put("(($q={1})x)))");
    send_text();
    // A lone '(' outside, then three opening parentheses.
    put("(x((($z={}))");
    send_text();
    put("$k=(($u={4}");
    send_text();
    put("(($w={5})");
    send_text();
    put("((");
    send_text();
    put("z(");
    send_text();
    put("(($n={}))");
    send_text();
    put("(($");
    add_byte(8'hc3);
    put("={}))");
    add_byte(8'hff);
    send_text();
    // The scalar count runs past its saturation point.
    put("(($s:integer={");
    repeat (260) put("7,");
    repeat (3) put("[0..9],");
    put("3}))");
    send_text();

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) send_random_text();
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
